### sv/box_iou_dedup_unit_macros.svh
// Assertion macros for the box IoU dedup unit
`ifndef BOX_IOU_DEDUP_UNIT_MACROS_SVH
`define BOX_IOU_DEDUP_UNIT_MACROS_SVH

// Property that must hold at every clock edge outside reset
`define BID_ASSERT_ALWAYS(label, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent
`define BID_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### sv/bid_pkg.sv
// Shared constants and types for the box IoU dedup unit
`default_nettype none

package bid_pkg;

    localparam int DEF_MAX_KEPT   = 256;
    localparam int DEF_COORD_BITS = 12;

    localparam int THR_W     = 17;
    localparam int FRAC_BITS = 16;
    localparam int SCORE_W   = 32;
    localparam int IDX_W     = 8;

    localparam logic [THR_W-1:0] THR_RESET = 17'd62259;

    typedef struct packed {
        logic busy;
        logic hit_valid;
        logic hit;
    } pipe_status_t;

endpackage

`default_nettype wire

### sv/bid_store.sv
// Kept box store: one write port, one read port with registered read data
`default_nettype none

module bid_store
    import bid_pkg::*;
#(
    parameter int DEPTH = DEF_MAX_KEPT,
    parameter int WIDTH = 4 * DEF_COORD_BITS
)(
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

### sv/bid_iou_pipe.sv
// IoU compare pipeline: stored box against candidate box, one pair per cycle
`default_nettype none

module bid_iou_pipe
    import bid_pkg::*;
#(
    parameter int COORD_BITS = DEF_COORD_BITS
)(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    issue,
    input  wire logic [4*COORD_BITS-1:0] kbox,
    input  wire logic [COORD_BITS-1:0]   cand_top,
    input  wire logic [COORD_BITS-1:0]   cand_left,
    input  wire logic [COORD_BITS-1:0]   cand_bottom,
    input  wire logic [COORD_BITS-1:0]   cand_right,
    input  wire logic [THR_W-1:0]        thr,
    output pipe_status_t                 status
);

    localparam int C      = COORD_BITS;
    localparam int SPW    = C + 1;
    localparam int AREA_W = 2 * C + 1;
    localparam int UNI_W  = 2 * C + 2;
    localparam int PROD_W = THR_W + UNI_W;

    function automatic logic [SPW-1:0] span(input logic [C-1:0] lo, input logic [C-1:0] hi);
        span = (hi >= lo) ? (SPW'(hi) - SPW'(lo) + SPW'(1)) : '0;
    endfunction

    logic [C-1:0] kt, kl, kb, kr;
    logic [C-1:0] it, il, ib, ir;

    logic              v0_reg, v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;
    logic [SPW-1:0]    ih_reg, iw_reg, kh_reg, kw_reg, ch_reg, cw_reg;
    logic [AREA_W-1:0] inter_reg, ak_reg, ac_reg, inter3_reg;
    logic [UNI_W-1:0]  uni_reg;
    logic [PROD_W-1:0] prod_reg, lhs_reg;
    logic              nz_reg, hit_reg;

    assign kt = kbox[4*C-1:3*C];
    assign kl = kbox[3*C-1:2*C];
    assign kb = kbox[2*C-1:C];
    assign kr = kbox[C-1:0];

    assign it = (kt > cand_top)    ? kt : cand_top;
    assign il = (kl > cand_left)   ? kl : cand_left;
    assign ib = (kb < cand_bottom) ? kb : cand_bottom;
    assign ir = (kr < cand_right)  ? kr : cand_right;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end
        else
        begin
            v0_reg <= issue;
            v1_reg <= v0_reg;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        // candidate area, stable while an item is scanned
        ch_reg <= span(cand_top, cand_bottom);
        cw_reg <= span(cand_left, cand_right);
        ac_reg <= AREA_W'(ch_reg) * AREA_W'(cw_reg);

        ih_reg <= span(it, ib);
        iw_reg <= span(il, ir);
        kh_reg <= span(kt, kb);
        kw_reg <= span(kl, kr);

        inter_reg <= AREA_W'(ih_reg) * AREA_W'(iw_reg);
        ak_reg    <= AREA_W'(kh_reg) * AREA_W'(kw_reg);

        uni_reg    <= UNI_W'(ak_reg) + UNI_W'(ac_reg) - UNI_W'(inter_reg);
        inter3_reg <= inter_reg;

        prod_reg <= PROD_W'(thr) * PROD_W'(uni_reg);
        lhs_reg  <= PROD_W'({inter3_reg, {FRAC_BITS{1'b0}}});
        nz_reg   <= (uni_reg != '0);

        hit_reg <= nz_reg && (lhs_reg >= prod_reg);
    end

    assign status.busy      = v0_reg | v1_reg | v2_reg | v3_reg | v4_reg | v5_reg;
    assign status.hit_valid = v5_reg;
    assign status.hit       = hit_reg;

endmodule

`default_nettype wire

### sv/box_iou_dedup_unit.sv
// Box IoU dedup unit: top level with sequencer, threshold register and output register
//
// Each accepted box is compared against every box kept in the current set by reading
// the kept-box store one entry per cycle into an IoU compare pipeline that returns a
// hit flag for each read issued. At most MAX_KEPT boxes are kept per set. The result
// is loaded into the output register after the scan reads and the pipeline drain; with
// an empty store no read is issued. The store has a single read port, so the scan reads
// one kept box at a time. A new box is taken the cycle after the previous result is
// loaded into the output register, and no new box is taken while one is in progress.
// The threshold may be written whenever the unit is idle; cfg_ready is always high.
`default_nettype none

module box_iou_dedup_unit
    import bid_pkg::*;
#(
    parameter int MAX_KEPT   = DEF_MAX_KEPT,
    parameter int COORD_BITS = DEF_COORD_BITS
)(
    input  wire logic                  clk,
    input  wire logic                  rst_n,

    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [THR_W-1:0]      cfg_data,

    input  wire logic                  in_valid,
    output logic                       in_stall,
    input  wire logic                  start_of_set,
    input  wire logic [COORD_BITS-1:0] box_top,
    input  wire logic [COORD_BITS-1:0] box_left,
    input  wire logic [COORD_BITS-1:0] box_bottom,
    input  wire logic [COORD_BITS-1:0] box_right,
    input  wire logic [SCORE_W-1:0]    box_score,

    output logic                       out_valid,
    input  wire logic                  out_stall,
    output logic                       kept,
    output logic                       dropped_full,
    output logic [IDX_W-1:0]           kept_index,
    output logic [COORD_BITS-1:0]      out_top,
    output logic [COORD_BITS-1:0]      out_left,
    output logic [COORD_BITS-1:0]      out_bottom,
    output logic [COORD_BITS-1:0]      out_right,
    output logic [SCORE_W-1:0]         out_score
);

    localparam int AW = $clog2(MAX_KEPT);
    localparam int CW = $clog2(MAX_KEPT + 1);
    localparam int EW = 4 * COORD_BITS;

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_SCAN  = 2'd1;
    localparam logic [1:0] S_DRAIN = 2'd2;
    localparam logic [1:0] S_OUT   = 2'd3;

    logic [1:0]       state_reg, state_next;
    logic [CW-1:0]    kept_count_reg, kept_count_next;
    logic [CW-1:0]    scan_idx_reg, scan_idx_next;
    logic             dup_reg, dup_next;
    logic [THR_W-1:0] thr_reg;
    logic             out_valid_reg, out_valid_next;

    logic [COORD_BITS-1:0] cand_top_reg, cand_left_reg, cand_bottom_reg, cand_right_reg;
    logic [SCORE_W-1:0]    cand_score_reg;
    logic                  kept_reg, dropped_reg;
    logic [IDX_W-1:0]      kept_index_reg;
    logic [COORD_BITS-1:0] out_top_reg, out_left_reg, out_bottom_reg, out_right_reg;
    logic [SCORE_W-1:0]    out_score_reg;

    logic         accept;
    logic         issue;
    logic         load;
    logic         room;
    logic         keep;
    logic [EW-1:0] rd_data;
    pipe_status_t pst;

    assign cfg_ready = 1'b1;
    assign in_stall  = (state_reg != S_IDLE);
    assign accept    = in_valid && !in_stall;
    assign issue     = (state_reg == S_SCAN) && (scan_idx_reg < kept_count_reg);
    assign load      = (state_reg == S_OUT) && (!out_valid_reg || !out_stall);
    assign room      = (kept_count_reg < CW'(MAX_KEPT));
    assign keep      = !dup_reg && room;

    always_comb
    begin
        state_next      = state_reg;
        kept_count_next = kept_count_reg;
        scan_idx_next   = scan_idx_reg;
        dup_next        = dup_reg;
        out_valid_next  = out_valid_reg && out_stall;

        if (pst.hit_valid && pst.hit)
        begin
            dup_next = 1'b1;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    kept_count_next = start_of_set ? '0 : kept_count_reg;
                    scan_idx_next   = '0;
                    dup_next        = 1'b0;
                    state_next      = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (issue)
                begin
                    scan_idx_next = scan_idx_reg + CW'(1);
                end
                else
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                if (!pst.busy)
                begin
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                if (load)
                begin
                    out_valid_next = 1'b1;
                    if (keep)
                    begin
                        kept_count_next = kept_count_reg + CW'(1);
                    end
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            kept_count_reg <= '0;
            scan_idx_reg   <= '0;
            dup_reg        <= 1'b0;
            thr_reg        <= THR_RESET;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            kept_count_reg <= kept_count_next;
            scan_idx_reg   <= scan_idx_next;
            dup_reg        <= dup_next;
            out_valid_reg  <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                thr_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cand_top_reg    <= box_top;
            cand_left_reg   <= box_left;
            cand_bottom_reg <= box_bottom;
            cand_right_reg  <= box_right;
            cand_score_reg  <= box_score;
        end
        if (load)
        begin
            kept_reg       <= keep;
            dropped_reg    <= !dup_reg && !room;
            kept_index_reg <= keep ? IDX_W'(kept_count_reg) : '0;
            out_top_reg    <= cand_top_reg;
            out_left_reg   <= cand_left_reg;
            out_bottom_reg <= cand_bottom_reg;
            out_right_reg  <= cand_right_reg;
            out_score_reg  <= cand_score_reg;
        end
    end

    bid_store #(
        .DEPTH (MAX_KEPT),
        .WIDTH (EW)
    ) u_store (
        .clk     (clk),
        .wr_en   (load && keep),
        .wr_addr (kept_count_reg[AW-1:0]),
        .wr_data ({cand_top_reg, cand_left_reg, cand_bottom_reg, cand_right_reg}),
        .rd_en   (issue),
        .rd_addr (scan_idx_reg[AW-1:0]),
        .rd_data (rd_data)
    );

    bid_iou_pipe #(
        .COORD_BITS (COORD_BITS)
    ) u_pipe (
        .clk         (clk),
        .rst_n       (rst_n),
        .issue       (issue),
        .kbox        (rd_data),
        .cand_top    (cand_top_reg),
        .cand_left   (cand_left_reg),
        .cand_bottom (cand_bottom_reg),
        .cand_right  (cand_right_reg),
        .thr         (thr_reg),
        .status      (pst)
    );

    assign out_valid    = out_valid_reg;
    assign kept         = kept_reg;
    assign dropped_full = dropped_reg;
    assign kept_index   = kept_index_reg;
    assign out_top      = out_top_reg;
    assign out_left     = out_left_reg;
    assign out_bottom   = out_bottom_reg;
    assign out_right    = out_right_reg;
    assign out_score    = out_score_reg;

endmodule

`default_nettype wire

### sv/bid_checker.sv
// Port-level checker for the box IoU dedup unit, bound to the top level
`default_nettype none

`include "box_iou_dedup_unit_macros.svh"

module bid_checker
    import bid_pkg::*;
(
    input wire logic             clk,
    input wire logic             rst_n,
    input wire logic             in_valid,
    input wire logic             in_stall,
    input wire logic             out_valid,
    input wire logic             out_stall,
    input wire logic             kept,
    input wire logic             dropped_full,
    input wire logic [IDX_W-1:0] kept_index
);

    `BID_ASSERT_ALWAYS(a_kept_xor_dropped, !(out_valid && kept && dropped_full), "kept and dropped_full both set")
    `BID_ASSERT_ALWAYS(a_index_zero, !(out_valid && !kept && (kept_index != '0)), "kept_index nonzero on a box not kept")
    `BID_ASSERT_NEXT(a_busy_after_in, in_valid && !in_stall, in_stall, "input taken again right after a transfer")
    `BID_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(kept) && $stable(kept_index), "stalled result changed")

endmodule

bind box_iou_dedup_unit bid_checker u_bid_checker (.*);

`default_nettype wire
